// ===== rtl/bm3_pkg.sv =====
// shared constants and types for the 3x3 binary morphology unit
`timescale 1ns / 1ps
`default_nettype none
package bm3_pkg;

  // field widths
  localparam int unsigned PixW   = 8;
  localparam int unsigned RowW   = 12;
  localparam int unsigned OutColW = 10;
  localparam int unsigned FwW    = 11;
  localparam int unsigned FhW    = 13;
  localparam int unsigned CfgW   = 13;
  localparam int unsigned CfgAW  = 2;
  // common width for position compares
  localparam int unsigned PosW   = 13;

  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned MinSize   = 3;

  localparam logic [PixW-1:0] SetValue = 8'd255;

  // configuration register indexes
  typedef enum logic [CfgAW-1:0] {
    REG_MORPH_MODE   = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } bm3_reg_e;

  // line store entry: bit0 = previous row, bit1 = row before that
  typedef logic [1:0] bm3_lbits_t;

endpackage
`default_nettype wire

// ===== rtl/bm3_line_store.sv =====
// two-row line store of set bits, one entry per column
`timescale 1ns / 1ps
`default_nettype none
module bm3_line_store #(
  parameter int unsigned Depth = 1024
) (
  input  wire                          clk_i,
  input  wire                          rd_en_i,
  input  wire  [$clog2(Depth)-1:0]     rd_addr_i,
  output bm3_pkg::bm3_lbits_t          rd_data_o,
  input  wire                          wr_en_i,
  input  wire  [$clog2(Depth)-1:0]     wr_addr_i,
  input  bm3_pkg::bm3_lbits_t          wr_data_i
);
  import bm3_pkg::*;

  bm3_lbits_t mem [Depth];
  bm3_lbits_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// ===== rtl/bm3_kernel.sv =====
// 3x3 window register and erosion / dilation decision
`timescale 1ns / 1ps
`default_nettype none
module bm3_kernel (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   advance_i,
  input  wire                   mode_i,
  input  wire                   pix_bit_i,
  input  bm3_pkg::bm3_lbits_t   old_bits_i,
  output logic                  hit_o
);
  import bm3_pkg::*;

  logic [5:0] window_q;
  logic [5:0] window_d;
  logic [2:0] slice;
  logic [8:0] nine;

  // slice bit2 = two rows up, bit1 = one row up, bit0 = current row
  assign slice    = {old_bits_i[1], old_bits_i[0], pix_bit_i};
  assign nine     = {window_q, slice};
  assign window_d = nine[5:0];

  // dilation: any set, erosion: all set
  assign hit_o = mode_i ? (|nine) : (&nine);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (advance_i) begin
      window_q <= window_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/binary_morphology_3x3_unit.sv =====
// top level of the 3x3 binary erosion / dilation unit
`timescale 1ns / 1ps
`default_nettype none
// throughput: one pixel per cycle unless the output stalls, set by one line store
//   read and one write per pixel; a result passes the pixel stage (with line store
//   read register), then the result register
// a stalled result register holds the pixel stage, which in turn drops in_ready_o
// reset (async, active low) clears counters, window, valid flags and config
//   (erosion, 640 x 480); line store contents stay undefined until written
module binary_morphology_3x3_unit #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration writes
  input  wire                          cfg_we_i,
  input  wire  [bm3_pkg::CfgAW-1:0]    cfg_addr_i,
  input  wire  [bm3_pkg::CfgW-1:0]     cfg_wdata_i,
  // pixel input
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [bm3_pkg::PixW-1:0]     pixel_value_i,
  // result output
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [bm3_pkg::PixW-1:0]     out_pixel_o,
  output logic [bm3_pkg::RowW-1:0]     out_row_o,
  output logic [bm3_pkg::OutColW-1:0]  out_col_o,
  output logic                         frame_last_o
);
  import bm3_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_WIDTH);

  // configuration registers
  logic            mode_q;
  logic [FwW-1:0]  fwidth_q;
  logic [FhW-1:0]  fheight_q;

  // effective frame size, clamped to the supported range
  logic [PosW-1:0] w_eff;
  logic [PosW-1:0] h_eff;

  // position of the next incoming pixel
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  // pixel stage: holds the accepted pixel while its line store entry is read
  logic            a_valid_q;
  logic            a_bit_q;
  logic [ColW-1:0] a_col_q;
  logic [RowW-1:0] a_row_q;

  // result register
  logic               out_valid_q;
  logic [PixW-1:0]    out_pixel_q;
  logic [RowW-1:0]    out_row_q;
  logic [OutColW-1:0] out_col_q;
  logic               out_last_q;

  logic            in_xfer;
  logic            advance;
  logic            hit;
  logic            emit;
  logic            last;
  logic [PosW-1:0] a_col_ext;
  logic [PosW-1:0] a_row_ext;
  logic [PosW-1:0] col_ext;
  logic [PosW-1:0] row_ext;
  logic [PosW-1:0] col_m1;
  logic [PosW-1:0] row_m1;
  bm3_lbits_t      old_bits;
  bm3_lbits_t      new_bits;

  // ---------------------------------------------------------------------------
  // configuration port, writes to unknown indexes are dropped
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      fwidth_q  <= FwW'(640);
      fheight_q <= FhW'(480);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_MORPH_MODE:   mode_q    <= cfg_wdata_i[0];
        REG_FRAME_WIDTH:  fwidth_q  <= cfg_wdata_i[FwW-1:0];
        REG_FRAME_HEIGHT: fheight_q <= cfg_wdata_i[FhW-1:0];
        default: ;
      endcase
    end
  end

  // clamp width to [3, MAX_WIDTH] and height to [3, 4096]
  always_comb begin
    if (PosW'(fwidth_q) < PosW'(MinSize)) begin
      w_eff = PosW'(MinSize);
    end else if (PosW'(fwidth_q) > PosW'(MAX_WIDTH)) begin
      w_eff = PosW'(MAX_WIDTH);
    end else begin
      w_eff = PosW'(fwidth_q);
    end
    if (fheight_q < PosW'(MinSize)) begin
      h_eff = PosW'(MinSize);
    end else if (fheight_q > PosW'(MaxHeight)) begin
      h_eff = PosW'(MaxHeight);
    end else begin
      h_eff = fheight_q;
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: the pixel stage moves on whenever the result register is free
  // ---------------------------------------------------------------------------
  assign advance    = a_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !a_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // raster counters, wrap at the end of a row and of a frame
  // ---------------------------------------------------------------------------
  assign col_ext = PosW'(col_q);
  assign row_ext = PosW'(row_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_ext + PosW'(1) >= w_eff) begin
      col_d = '0;
      if (row_ext + PosW'(1) >= h_eff) begin
        row_d = '0;
      end else begin
        row_d = row_q + RowW'(1);
      end
    end else begin
      col_d = col_q + ColW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_xfer) begin
        a_valid_q <= 1'b1;
      end else if (advance) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  // pixel stage payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_bit_q <= |pixel_value_i;
      a_col_q <= col_q;
      a_row_q <= row_q;
    end
  end

  // ---------------------------------------------------------------------------
  // line store: read at transfer, write back the shifted bits as the pixel
  // leaves the pixel stage; consecutive pixels never share a column
  // ---------------------------------------------------------------------------
  assign new_bits = {old_bits[0], a_bit_q};

  bm3_line_store #(
    .Depth (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_xfer),
    .rd_addr_i (col_q),
    .rd_data_o (old_bits),
    .wr_en_i   (advance),
    .wr_addr_i (a_col_q),
    .wr_data_i (new_bits)
  );

  // window and morphology decision
  bm3_kernel u_kernel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .mode_i     (mode_q),
    .pix_bit_i  (a_bit_q),
    .old_bits_i (old_bits),
    .hit_o      (hit)
  );

  // ---------------------------------------------------------------------------
  // interior test: the window is complete from row 2, column 2 on, and
  // pixels beyond the current frame size report nothing
  // ---------------------------------------------------------------------------
  assign a_col_ext = PosW'(a_col_q);
  assign a_row_ext = PosW'(a_row_q);
  assign col_m1    = a_col_ext - PosW'(1);
  assign row_m1    = a_row_ext - PosW'(1);

  assign emit = (a_row_ext >= PosW'(2)) && (a_col_ext >= PosW'(2))
             && (a_row_ext < h_eff) && (a_col_ext < w_eff);
  assign last = (a_row_ext == h_eff - PosW'(1)) && (a_col_ext == w_eff - PosW'(1));

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_pixel_q <= hit ? SetValue : '0;
      out_row_q   <= row_m1[RowW-1:0];
      out_col_q   <= col_m1[OutColW-1:0];
      out_last_q  <= last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_pixel_o  = out_pixel_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign frame_last_o = out_last_q;

`ifndef SYNTHESIS
  // input only stalls when a pixel is held behind a full result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (a_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked pixel stage");

  // every transferred pixel lands in the pixel stage
  a_stage_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> a_valid_q)
    else $error("accepted pixel lost before the pixel stage");

  // column counter stays inside the line store
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PosW'(col_q) < PosW'(MAX_WIDTH))
    else $error("column counter beyond line store depth");

  // a reported pixel is never on the top row or left column
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_row_o != '0 && out_col_o != '0))
    else $error("border pixel reported");
`endif

endmodule
`default_nettype wire
